// ----- sv/fpa_pkg.sv -----
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared constants and types for the single-precision adder.
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam int EXP_WIDTH_DEF  = 8;
   localparam int FRAC_WIDTH_DEF = 23;
   localparam int GRS_BITS       = 3;
   localparam int WORD_WIDTH     = 32;

   // controller to datapath commands
   typedef struct packed {
      logic load;      // capture operands and unpack
      logic align;     // swap and align
      logic addsub;    // add or subtract significands
      logic norm_step; // one normalize shift step
      logic finish;    // pack the result
   } fpa_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic special;   // result already decided
      logic norm_done; // normalization finished
   } fpa_status_type;

endpackage

// ----- sv/fpa_if.sv -----
// ----------------------------------------------------------------------------
// fpa_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface fpa_if #(
   parameter int WIDTH = 32
) (
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- sv/fpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// fpa_ctrl
// Sequencer: unpack, align, add, normalize step by step, pack, hand out;
// special cases go from align straight to hand out.
module fpa_ctrl
   import fpa_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   output logic           out_valid,
   input  logic           out_ready,
   output fpa_cmd_type    cmd,
   input  fpa_status_type status
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ALIGN = 3'd1;
   localparam logic [2:0] ST_ADD   = 3'd2;
   localparam logic [2:0] ST_NORM  = 3'd3;
   localparam logic [2:0] ST_PACK  = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            // align also latches a special result when there is one
            cmd.align = 1'b1;
            if (status.special) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.addsub = 1'b1;
            state_in   = ST_NORM;
         end
         ST_NORM: begin
            if (status.norm_done) begin
               state_in = ST_PACK;
            end else begin
               cmd.norm_step = 1'b1;
            end
         end
         ST_PACK: begin
            cmd.finish = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            out_valid = 1'b1;
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // an item is only taken when nothing is in flight
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> (state_ff == ST_ALIGN))
      else $error("item taken outside idle");
   // a result is held until taken
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid)
      else $error("result dropped");
   // never accept and deliver together
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(in_ready && out_valid))
      else $error("accept and deliver overlap");
`endif

endmodule

// ----- sv/fpa_dp.sv -----
// ----------------------------------------------------------------------------
// fpa_dp
// Datapath: unpack, special cases, alignment, add/sub, one-bit normalize
// steps, truncating pack.
// ----------------------------------------------------------------------------
module fpa_dp
   import fpa_pkg::*;
#(
   parameter int EXP_WIDTH  = EXP_WIDTH_DEF,
   parameter int FRAC_WIDTH = FRAC_WIDTH_DEF
) (
   input  logic                              clock,
   input  fpa_cmd_type                       cmd,
   output fpa_status_type                    status,
   input  logic [EXP_WIDTH+FRAC_WIDTH:0]     a_in,
   input  logic [EXP_WIDTH+FRAC_WIDTH:0]     b_in,
   output logic [EXP_WIDTH+FRAC_WIDTH:0]     result
);

   localparam int W    = EXP_WIDTH + FRAC_WIDTH + 1;
   localparam int SW   = FRAC_WIDTH + 1;            // significand with hidden
   localparam int MW   = SW + GRS_BITS + 1;         // sum with carry
   localparam int EW   = EXP_WIDTH + 1;             // exponent with headroom
   localparam logic [EXP_WIDTH-1:0] EMAX = '1;

   logic [W-1:0] a, b;
   logic sa, sb;
   logic [EXP_WIDTH-1:0] ea, eb, xa, xb;
   logic [FRAC_WIDTH-1:0] fa, fb;
   logic [SW-1:0] ma, mb;
   logic nan_a, nan_b, inf_a, inf_b, swap;
   logic [EXP_WIDTH-1:0] d;
   logic [MW-1:0] big_v, small_v, bt, lowmask;
   logic sticky;

   logic [W-1:0]     res_ff, res_in;
   logic             special_in;
   logic             s_ff;
   logic             sb_ff;
   logic [EW-1:0]    e_ff, e_in;
   logic [MW-1:0]    big_ff, bt_ff, m_ff, m_in;
   logic             sticky_ff;
   logic [W-1:0]     a_ff, b_ff;

   // unpack from captured operands
   always_comb begin
      a = a_ff;
      b = b_ff;
      sa = a[W-1];
      sb = b[W-1];
      ea = a[W-2:FRAC_WIDTH];
      eb = b[W-2:FRAC_WIDTH];
      fa = a[FRAC_WIDTH-1:0];
      fb = b[FRAC_WIDTH-1:0];
      ma = {(ea != '0), fa};
      mb = {(eb != '0), fb};
      xa = (ea != '0) ? ea : EXP_WIDTH'(1);
      xb = (eb != '0) ? eb : EXP_WIDTH'(1);
      nan_a = (ea == EMAX) && (fa != '0);
      nan_b = (eb == EMAX) && (fb != '0);
      inf_a = (ea == EMAX);
      inf_b = (eb == EMAX);
      swap = (xa < xb) || ((xa == xb) && (ma < mb));
      // special results
      special_in = 1'b1;
      res_in = '0;
      if (nan_a) begin
         res_in = a | (W'(1) << (FRAC_WIDTH - 1));
      end else if (nan_b) begin
         res_in = b | (W'(1) << (FRAC_WIDTH - 1));
      end else if (inf_a && inf_b) begin
         res_in = (sa != sb) ? {1'b0, EMAX, 1'b1, {(FRAC_WIDTH-1){1'b0}}} : a;
      end else if (inf_a) begin
         res_in = a;
      end else if (inf_b) begin
         res_in = b;
      end else if (ma == '0 && mb == '0) begin
         res_in = {(sa & sb), {(W-1){1'b0}}};
      end else if (sa != sb && xa == xb && ma == mb) begin
         res_in = '0;
      end else begin
         special_in = 1'b0;
      end
      // alignment
      big_v   = swap ? {1'b0, mb, {GRS_BITS{1'b0}}} : {1'b0, ma, {GRS_BITS{1'b0}}};
      small_v = swap ? {1'b0, ma, {GRS_BITS{1'b0}}} : {1'b0, mb, {GRS_BITS{1'b0}}};
      d = swap ? (xb - xa) : (xa - xb);
      if (d >= EXP_WIDTH'(MW)) begin
         bt = '0;
         lowmask = '1;
      end else begin
         bt = small_v >> d;
         lowmask = (MW'(1) << d) - MW'(1);
      end
      sticky = (small_v & lowmask) != '0;
   end

   // normalization step
   always_comb begin
      m_in = m_ff;
      e_in = e_ff;
      if (m_ff[MW-1]) begin
         m_in = m_ff >> 1;
         e_in = e_ff + EW'(1);
      end else if (!m_ff[MW-2] && e_ff > EW'(1)) begin
         m_in = m_ff << 1;
         e_in = e_ff - EW'(1);
      end
   end

   assign status.special   = special_in;
   assign status.norm_done = !m_ff[MW-1] && (m_ff[MW-2] || e_ff <= EW'(1));

   // datapath registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
      if (cmd.align) begin
         res_ff    <= res_in;
         s_ff      <= swap ? sb : sa;
         sb_ff     <= swap ? sa : sb;
         e_ff      <= EW'(swap ? xb : xa);
         big_ff    <= big_v;
         bt_ff     <= bt;
         sticky_ff <= sticky;
      end
      if (cmd.addsub) begin
         m_ff <= (s_ff == sb_ff) ? (big_ff + bt_ff)
                                 : (big_ff - bt_ff - MW'(sticky_ff));
      end
      if (cmd.norm_step) begin
         m_ff <= m_in;
         e_ff <= e_in;
      end
      if (cmd.finish) begin
         if (e_ff >= EW'(EMAX)) begin
            res_ff <= {s_ff, EMAX - EXP_WIDTH'(1), {FRAC_WIDTH{1'b1}}};
         end else if (!m_ff[MW-2]) begin
            res_ff <= {s_ff, {EXP_WIDTH{1'b0}}, m_ff[MW-3:GRS_BITS]};
         end else begin
            res_ff <= {s_ff, e_ff[EXP_WIDTH-1:0], m_ff[MW-3:GRS_BITS]};
         end
      end
   end

   assign result = res_ff;

`ifndef SYNTHESIS
   // one command at a time
   a_onecmd: assert property (@(posedge clock)
      $onehot0({cmd.load, cmd.align, cmd.addsub, cmd.norm_step, cmd.finish}))
      else $error("overlapping commands");
   // a normalize step never starts once done
   a_step: assert property (@(posedge clock)
      cmd.norm_step |-> !status.norm_done)
      else $error("normalize step past done");
   // no carry bit is left in the sum at pack
   a_range: assert property (@(posedge clock)
      cmd.finish |-> !m_ff[MW-1])
      else $error("unnormalized pack");
`endif

endmodule

// ----- sv/fp32_adder.sv -----
// ----------------------------------------------------------------------------
// fp32_adder
// IEEE-754 single-precision adder, round toward zero.
// ----------------------------------------------------------------------------
// One operand pair at a time: after acceptance the sequencer unpacks the
// operands, sorts out NaN, infinity and zero cases and aligns them in the same
// state, then adds, normalizes one bit of shift per step, packs, and then holds
// the result until taken. Special cases go from alignment straight to the
// result; a deep cancellation takes longest, set by the one-bit normalize
// shifter.
module fp32_adder
   import fpa_pkg::*;
#(
   parameter int EXP_WIDTH  = EXP_WIDTH_DEF,
   parameter int FRAC_WIDTH = FRAC_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   fpa_if.sink  req_operand_a,
   fpa_if.sink  req_operand_b,
   fpa_if.source rsp_sum
);

   fpa_cmd_type    cmd;
   fpa_status_type status;
   logic           in_ready;
   logic           both_valid;

   assign both_valid          = req_operand_a.valid && req_operand_b.valid;
   assign req_operand_a.ready = in_ready && req_operand_b.valid;
   assign req_operand_b.ready = in_ready && req_operand_a.valid;

   // controller
   fpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (both_valid),
      .in_ready  (in_ready),
      .out_valid (rsp_sum.valid),
      .out_ready (rsp_sum.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath
   fpa_dp #(
      .EXP_WIDTH  (EXP_WIDTH),
      .FRAC_WIDTH (FRAC_WIDTH)
   ) u_dp (
      .clock  (clock),
      .cmd    (cmd),
      .status (status),
      .a_in   (req_operand_a.data),
      .b_in   (req_operand_b.data),
      .result (rsp_sum.data)
   );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the single-precision adder: directed operand pairs covering zeros,
// subnormals, infinities, NaNs, overflow and cancellation, then random pairs
// with random idle cycles on both channels, each sum compared in order
// against a typed value or a bit-exact round-toward-zero predictor.
// ----------------------------------------------------------------------------
module testbench;
   import fpa_pkg::*;

   localparam int          HALF_PERIOD   = 4;
   localparam int          RESET_CYCLES  = 11;
   localparam int          RANDOM_ITEMS  = 600;
   localparam int          STALL_CYCLES  = 250;
   localparam int          WATCHDOG_MAX  = 3000;
   localparam int          DRAIN_CYCLES  = 60;
   localparam logic [31:0] QNAN_DEFAULT  = 32'h7FC0_0000;
   localparam logic [31:0] MAX_FINITE    = 32'h7F7F_FFFF;
   localparam logic [31:0] QUIET_MASK    = 32'h0040_0000;

   typedef struct {
      logic [31:0] op_a;
      logic [31:0] op_b;
      logic [31:0] sum;
      bit          typed;
   } add_row_type;

   logic clock;
   logic reset;

   fpa_if #(.WIDTH(WORD_WIDTH)) a_if ();
   fpa_if #(.WIDTH(WORD_WIDTH)) b_if ();
   fpa_if #(.WIDTH(WORD_WIDTH)) sum_if ();

   fp32_adder u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_operand_a (a_if),
      .req_operand_b (b_if),
      .rsp_sum       (sum_if)
   );

   logic [31:0] sum_queue[$];
   int          err_count;
   int          pair_count;
   int          sum_count;
   int          special_count;
   int          idle_cycles;

   // bit-exact sum, round toward zero
   function automatic logic [31:0] fp_sum(logic [31:0] a, logic [31:0] b);
      logic        sa, sb, st, s;
      logic [7:0]  ea, eb;
      logic [22:0] fa, fb;
      logic [23:0] ma, mb, tm;
      int unsigned xa, xb, tx, d, e;
      logic [63:0] big, sml, bt, m;
      bit          sticky;
      sa = a[31];
      sb = b[31];
      ea = a[30:23];
      eb = b[30:23];
      fa = a[22:0];
      fb = b[22:0];
      // nan, infinity
      if (ea == 8'hFF && fa != 0) return a | QUIET_MASK;
      if (eb == 8'hFF && fb != 0) return b | QUIET_MASK;
      if (ea == 8'hFF && eb == 8'hFF) return (sa != sb) ? QNAN_DEFAULT : a;
      if (ea == 8'hFF) return a;
      if (eb == 8'hFF) return b;
      // unpack
      ma = (ea != 0) ? {1'b1, fa} : {1'b0, fa};
      mb = (eb != 0) ? {1'b1, fb} : {1'b0, fb};
      xa = (ea != 0) ? ea : 1;
      xb = (eb != 0) ? eb : 1;
      if (ma == 0 && mb == 0) return {sa & sb, 31'd0};
      // larger magnitude first
      if (xa < xb || (xa == xb && ma < mb)) begin
         st = sa; sa = sb; sb = st;
         tm = ma; ma = mb; mb = tm;
         tx = xa; xa = xb; xb = tx;
      end
      if (sa != sb && xa == xb && ma == mb) return 32'd0;
      // align with guard, round and sticky
      big = 64'(ma) << GRS_BITS;
      sml = 64'(mb) << GRS_BITS;
      d = xa - xb;
      if (d >= 40) begin
         bt = 0;
         sticky = (sml != 0);
      end else begin
         bt = sml >> d;
         sticky = ((sml & ((64'd1 << d) - 1)) != 0);
      end
      if (sa == sb) m = big + bt;
      else m = big - bt - (sticky ? 64'd1 : 64'd0);
      // normalize
      s = sa;
      e = xa;
      while (m >= (64'd1 << 27)) begin
         m = m >> 1;
         e = e + 1;
      end
      while (m < (64'd1 << 26) && e > 1) begin
         m = m << 1;
         e = e - 1;
      end
      if (e >= 255) return {s, MAX_FINITE[30:0]};
      m = m >> GRS_BITS;
      if (m < (64'd1 << 23)) return {s, 8'd0, m[22:0]};
      return {s, e[7:0], m[22:0]};
   endfunction

   function automatic bit is_special(logic [31:0] a, logic [31:0] b);
      return (a[30:23] == 8'hFF) || (b[30:23] == 8'hFF) ||
             (a[30:0] == 0) || (b[30:0] == 0);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // random operand pair, mostly structured
   function automatic void random_pair(output logic [31:0] a, output logic [31:0] b);
      int kind;
      a = $urandom;
      b = $urandom;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1: ;
         2, 3: begin
            // close exponents, either sign
            b[30:23] = a[30:23] + 8'($urandom_range(0, 4)) - 8'd2;
         end
         4: begin
            // near cancellation
            b = {~a[31], a[30:0] ^ 31'($urandom_range(0, 255))};
         end
         5: begin
            // subnormal b, a subnormal or smallest normal
            a[30:23] = ($urandom_range(0, 1) == 1) ? 8'd0 : 8'd1;
            b[30:23] = 8'd0;
         end
         6: begin
            // wide exponent gap
            b[30:23] = a[30:23] - 8'($urandom_range(20, 60));
         end
         7: begin
            // near overflow
            a[30:23] = 8'hFE;
            b[30:23] = 8'($urandom_range(250, 254));
         end
         8: begin
            // specials
            if ($urandom_range(0, 1) == 1) a[30:23] = 8'hFF;
            else b[30:0] = 0;
            if ($urandom_range(0, 3) == 0) a[22:0] = 0;
         end
         default: begin
            // equal exponents
            b[30:23] = a[30:23];
         end
      endcase
      if (b[30:23] == 8'hFF && kind != 8) b[30:23] = 8'hFE;
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // present one operand pair; a and b handshakes are tracked independently
   task automatic send_pair(logic [31:0] a, logic [31:0] b, logic [31:0] sum);
      int gap;
      bit done_a, done_b, fire_a, fire_b;
      gap = pick_gap();
      if (pair_count >= 320 && pair_count < 380) gap = 0;
      if (gap > 0) begin
         a_if.valid <= 1'b0;
         b_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      a_if.valid <= 1'b1;
      a_if.data  <= a;
      b_if.valid <= 1'b1;
      b_if.data  <= b;
      done_a = 0;
      done_b = 0;
      while (!(done_a && done_b)) begin
         @(negedge clock);
         fire_a = !done_a && a_if.valid && a_if.ready;
         fire_b = !done_b && b_if.valid && b_if.ready;
         @(posedge clock);
         if (fire_a) done_a = 1;
         if (fire_b) done_b = 1;
         // drop a channel once taken while the other still waits
         if (fire_a && !done_b) a_if.valid <= 1'b0;
         if (fire_b && !done_a) b_if.valid <= 1'b0;
      end
      sum_queue.push_back(sum);
      pair_count++;
      if (is_special(a, b)) special_count++;
   endtask

   task automatic wait_drained();
      while (sum_queue.size() != 0) @(posedge clock);
   endtask

   // stimulus
   initial begin
      add_row_type rows[$];
      logic [31:0] ra, rb;
      err_count     = 0;
      pair_count    = 0;
      special_count = 0;
      reset         = 1'b1;
      a_if.valid    = 1'b0;
      a_if.data     = '0;
      b_if.valid    = 1'b0;
      b_if.data     = '0;
      rows = '{
         '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1},
         '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1},
         '{32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1},
         '{32'h7F80_0000, 32'hFF80_0000, QNAN_DEFAULT,  1},
         '{32'h7F80_0000, 32'h7F80_0000, 32'h7F80_0000, 1},
         '{32'h7F80_0001, 32'h3F80_0000, 32'h7FC0_0001, 1},
         '{32'h3F80_0000, 32'hFF80_0001, 32'hFFC0_0001, 1},
         '{32'hFFFF_FFFF, 32'h7F80_0001, 32'hFFFF_FFFF, 1},
         '{32'h7F80_0000, 32'h3F80_0000, 32'h7F80_0000, 1},
         '{32'h3F80_0000, 32'hFF80_0000, 32'hFF80_0000, 1},
         '{32'h7F7F_FFFF, 32'h7F7F_FFFF, MAX_FINITE,    1},
         '{32'hFF7F_FFFF, 32'hFF7F_FFFF, 32'hFF7F_FFFF, 1},
         '{32'h3F80_0000, 32'hBF80_0000, 32'h0000_0000, 1},
         '{32'h3F80_0000, 32'h3F80_0000, 32'h0, 0},
         '{32'h0000_0001, 32'h0000_0001, 32'h0, 0},
         '{32'h007F_FFFF, 32'h0000_0001, 32'h0, 0},
         '{32'h0080_0000, 32'h807F_FFFF, 32'h0, 0},
         '{32'h3F80_0000, 32'h0000_0001, 32'h0, 0},
         '{32'h3F80_0000, 32'hB380_0001, 32'h0, 0},
         '{32'h3F80_0001, 32'hBF80_0000, 32'h0, 0},
         '{32'h4B7F_FFFF, 32'hCB7F_FFFE, 32'h0, 0},
         '{32'hC000_0000, 32'h3FFF_FFFF, 32'h0, 0},
         '{32'h7F7F_FFFF, 32'h8000_0001, 32'h0, 0},
         '{32'h0000_0000, 32'h8123_4567, 32'h0, 0}
      };
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed table
      foreach (rows[i]) begin
         send_pair(rows[i].op_a, rows[i].op_b,
                   rows[i].typed ? rows[i].sum : fp_sum(rows[i].op_a, rows[i].op_b));
      end
      // sender holds off until every sum is back
      a_if.valid <= 1'b0;
      b_if.valid <= 1'b0;
      wait_drained();
      // random pairs
      repeat (RANDOM_ITEMS) begin
         random_pair(ra, rb);
         send_pair(ra, rb, fp_sum(ra, rb));
      end
      a_if.valid <= 1'b0;
      b_if.valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("checked %0d sums from %0d operand pairs, %0d with zero/inf/nan inputs",
               sum_count, pair_count, special_count);
      $display("sums left unchecked: %0d, errors: %0d", sum_queue.size(), err_count);
      if (err_count == 0 && sum_queue.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // receiver ready, random with short hold-offs, one long hold-off and an always-ready window
   initial begin
      int cycle;
      int hold;
      cycle = 0;
      hold  = 0;
      sum_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         cycle++;
         if (hold == 0 && cycle == 2500) hold = STALL_CYCLES;
         if (hold > 0) begin
            hold--;
            sum_if.ready <= 1'b0;
         end else if (cycle > 6000 && cycle < 7000) begin
            sum_if.ready <= 1'b1;
         end else if ($urandom_range(0, 19) == 0) begin
            sum_if.ready <= 1'b0;
            hold = $urandom_range(5, 25);
         end else begin
            sum_if.ready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   // sum checker, sampled mid-cycle
   initial begin
      logic [31:0] want;
      sum_count = 0;
      forever begin
         @(negedge clock);
         if (!reset && sum_if.valid && sum_if.ready) begin
            sum_count++;
            if (sum_queue.size() == 0) begin
               $error("unexpected sum %h", sum_if.data);
               err_count++;
            end else begin
               want = sum_queue.pop_front();
               if (sum_if.data !== want) begin
                  $error("sum: expected %h, actual %h", want, sum_if.data);
                  err_count++;
               end
            end
         end
      end
   end

   // watchdog on cycles without any item moving
   initial begin
      idle_cycles = 0;
      forever begin
         @(negedge clock);
         if ((a_if.valid && a_if.ready) || (b_if.valid && b_if.ready) ||
             (sum_if.valid && sum_if.ready) || reset) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_MAX) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

endmodule
